// ===== design/mdh_pkg.sv =====
// ----------------------------------------------------------------------------
// mdh_pkg: shared types and constants of the histogram engine
// Operation codes, register indexes and the command word that the front
// part hands to the back part.
// ----------------------------------------------------------------------------
package mdh_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BINS  = 2'd0;
  localparam logic [1:0] REG_RDIM  = 2'd1;
  localparam logic [1:0] REG_RLOW  = 2'd2;
  localparam logic [1:0] REG_RHIGH = 2'd3;

  // Configuration address width and bin number width.
  localparam int CFG_AW = 4;
  localparam int BIN_W  = 7;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  // Command word that the front part queues for the back part.
  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       dim;
    logic [BIN_W-1:0] bin;
    logic             hl;
    logic             dim_ok;
    logic             in_range;
  } mdh_cmd_t;

endpackage

// ===== design/multi_dim_histogram.sv =====
// Items other than an in-range accumulate go straight into the command queue;
// an accumulate inside its range first passes the bit-serial bin divider,
// and the front takes no new item while it divides. The back part carries out
// reads and accumulates with a table read-modify-write; a clear sweeps the table.
// Reset: synchronous, active low; after reset a clearing pass over all DIMS*MAX_BINS
// entries zeroes the count tables before the first queued item is carried out.
// ----------------------------------------------------------------------------
// multi_dim_histogram: per-dimension uniform-bin histogram engine
// A front part classifies items into bins, a short queue hands them to the
// back part, which counts them and returns the bin's counts.
// ----------------------------------------------------------------------------
module multi_dim_histogram import mdh_pkg::*; #(
  parameter int DIMS       = 16,
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_operation,
  input  logic [3:0]        in_dimension,
  input  logic signed [31:0] in_value,
  input  logic              in_highlighted,
  input  logic [5:0]        in_bin_select,
  output logic              empty,
  input  logic              pop,
  output logic [5:0]        out_bin_index,
  output logic [31:0]       out_bin_count,
  output logic [31:0]       out_marked_count,
  output logic [31:0]       out_dim_max_count
);

  mdh_cmd_t f_cmd;
  mdh_cmd_t b_cmd;
  logic     f_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  assign pready = 1'b1;

  // Front: registers and bin classification.
  mdh_front #(.DIMS(DIMS), .MAX_BINS(MAX_BINS)) u_front (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .push, .full, .in_operation, .in_dimension, .in_value, .in_highlighted,
    .in_bin_select, .q_push(f_push), .q_cmd(f_cmd), .q_full(q_full)
  );

  // Command queue.
  mdh_queue u_queue (
    .clk, .rst_n, .wr_en(f_push), .wr_cmd(f_cmd), .q_full(q_full),
    .rd_en(q_pop), .rd_cmd(b_cmd), .q_empty(q_empty)
  );

  // Back: count tables and result.
  mdh_back #(.DIMS(DIMS), .MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .q_cmd(b_cmd), .q_empty(q_empty), .q_pop(q_pop),
    .empty, .pop, .out_bin_index, .out_bin_count, .out_marked_count,
    .out_dim_max_count
  );

endmodule

// ===== design/mdh_front.sv =====
// ----------------------------------------------------------------------------
// mdh_front: configuration registers and bin classifier
// Holds the registers and the per-dimension bounds, accepts items and works
// out the bin of an accumulate item with a bit-serial divider.
// ----------------------------------------------------------------------------
module mdh_front import mdh_pkg::*; #(
  parameter int DIMS     = 16,
  parameter int MAX_BINS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_operation,
  input  logic [3:0]        in_dimension,
  input  logic signed [31:0] in_value,
  input  logic              in_highlighted,
  input  logic [5:0]        in_bin_select,
  output logic              q_push,
  output mdh_cmd_t          q_cmd,
  input  logic              q_full
);

  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int PW = 33 + BIN_W;

  typedef enum logic {F_IDLE, F_DIV} f_state_t;

  f_state_t           st_r;
  logic [BIN_W-1:0]   bins_r;
  logic [3:0]         rdim_r;
  logic [31:0]        rlow_r;
  logic [31:0]        rhigh_r;
  logic [31:0]        lo_r [DIMS];
  logic [31:0]        hi_r [DIMS];
  logic [PW-1:0]      rem_r;
  logic [32:0]        span_r;
  logic [BIN_W-1:0]   quo_r;
  logic [2:0]         step_r;
  mdh_cmd_t           cmd_r;

  logic               wr;
  logic               accept;
  logic [BIN_W-1:0]   n_eff;
  logic [DW-1:0]      di;
  logic signed [32:0] lo;
  logic signed [32:0] hi;
  logic signed [32:0] v;
  logic [32:0]        diff;
  logic [32:0]        span;
  logic [PW-1:0]      prod;
  logic               empty_rng;
  logic               below;
  logic               above;
  logic               go_div;
  mdh_cmd_t           cmd_now;
  logic [PW-1:0]      shifted;
  logic               ge;
  logic [BIN_W-1:0]   quo_nxt;

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_BINS:  prdata = {{(32-BIN_W){1'b0}}, bins_r};
      REG_RDIM:  prdata = {28'd0, rdim_r};
      REG_RLOW:  prdata = rlow_r;
      REG_RHIGH: prdata = rhigh_r;
      default:   prdata = 32'd0;
    endcase
  end

  // Effective bin number: zero acts as one, clamp to the table size.
  always_comb begin
    if (bins_r == '0) begin
      n_eff = BIN_W'(1);
    end else if (int'(bins_r) > MAX_BINS) begin
      n_eff = BIN_W'(MAX_BINS);
    end else begin
      n_eff = bins_r;
    end
  end

  // Range checks and numerator of the bin division.
  always_comb begin
    di        = DW'(in_dimension);
    lo        = {lo_r[di][31], lo_r[di]};
    hi        = {hi_r[di][31], hi_r[di]};
    v         = {in_value[31], in_value};
    diff      = 33'(v - lo);
    span      = 33'(hi - lo);
    prod      = diff * n_eff;
    empty_rng = (hi <= lo);
    below     = (v < lo);
    above     = (v >= hi);
  end

  // Command for the item on the input ports.
  always_comb begin
    cmd_now.op       = in_operation;
    cmd_now.dim      = in_dimension;
    cmd_now.hl       = in_highlighted;
    cmd_now.dim_ok   = (int'(in_dimension) < DIMS);
    cmd_now.in_range = ({1'b0, in_bin_select} < n_eff);
    cmd_now.bin      = '0;
    go_div           = 1'b0;
    if (in_operation == OP_READ) begin
      cmd_now.bin = {1'b0, in_bin_select};
    end else if (in_operation == OP_ACC) begin
      if (!empty_rng && above) begin
        cmd_now.bin = n_eff - BIN_W'(1);
      end
      go_div = cmd_now.dim_ok && !empty_rng && !below && !above;
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    shifted = PW'({{BIN_W{1'b0}}, span_r} << step_r);
    ge      = (rem_r >= shifted);
    quo_nxt = {quo_r[BIN_W-2:0], ge};
  end

  assign full   = (st_r != F_IDLE) || q_full;
  assign accept = push && !full;
  assign wr     = psel && penable && pwrite;
  assign q_push = (accept && !go_div) || (st_r == F_DIV && step_r == 3'd0);

  always_comb begin
    if (st_r == F_DIV) begin
      q_cmd     = cmd_r;
      q_cmd.bin = quo_nxt;
    end else begin
      q_cmd = cmd_now;
    end
  end

  // State, registers and divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      bins_r  <= BIN_W'(10);
      rdim_r  <= '0;
      rlow_r  <= '0;
      rhigh_r <= '0;
      for (int i = 0; i < DIMS; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else begin
      if (wr) begin
        case (paddr[3:2])
          REG_BINS: bins_r <= pwdata[BIN_W-1:0];
          REG_RDIM: rdim_r <= pwdata[3:0];
          REG_RLOW: rlow_r <= pwdata;
          REG_RHIGH: begin
            rhigh_r <= pwdata;
            if (int'(rdim_r) < DIMS) begin
              lo_r[DW'(rdim_r)] <= rlow_r;
              hi_r[DW'(rdim_r)] <= pwdata;
            end
          end
          default: ;
        endcase
      end
      case (st_r)
        F_IDLE: begin
          if (accept && go_div) begin
            st_r   <= F_DIV;
            cmd_r  <= cmd_now;
            rem_r  <= prod;
            span_r <= span;
            quo_r  <= '0;
            step_r <= 3'(BIN_W - 1);
          end
        end
        F_DIV: begin
          quo_r <= quo_nxt;
          if (ge) begin
            rem_r <= rem_r - shifted;
          end
          if (step_r == 3'd0) begin
            st_r <= F_IDLE;
          end else begin
            step_r <= step_r - 3'd1;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/mdh_queue.sv =====
// ----------------------------------------------------------------------------
// mdh_queue: command queue between front and back
// A short first-in first-out queue of command words.
// ----------------------------------------------------------------------------
module mdh_queue import mdh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  mdh_cmd_t wr_cmd,
  output logic     q_full,
  input  logic     rd_en,
  output mdh_cmd_t rd_cmd,
  output logic     q_empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  mdh_cmd_t         slot_r [QDEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W:0]   cnt_r;

  assign q_full  = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_cmd  = slot_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        slot_r[wp_r] <= wr_cmd;
        wp_r <= (wp_r == PTR_W'(QDEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == PTR_W'(QDEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== design/mdh_back.sv =====
// ----------------------------------------------------------------------------
// mdh_back: count tables and result register
// Carries out queued commands against the count memories with a
// read-modify-write, clears the tables by a sweep and holds the result.
// ----------------------------------------------------------------------------
module mdh_back import mdh_pkg::*; #(
  parameter int DIMS       = 16,
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mdh_cmd_t    q_cmd,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_bin_index,
  output logic [31:0] out_bin_count,
  output logic [31:0] out_marked_count,
  output logic [31:0] out_dim_max_count
);

  localparam int DEPTH = DIMS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_EX} b_state_t;

  b_state_t              st_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  clr_res_r;
  logic                  out_v_r;
  mdh_cmd_t              cmd_r;
  logic [COUNT_BITS-1:0] max_r [DIMS];
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0] mrk_mem [DEPTH];
  logic [COUNT_BITS-1:0] rdc_r;
  logic [COUNT_BITS-1:0] rdm_r;

  logic                  we;
  logic [AW-1:0]         wa;
  logic [AW-1:0]         ra;
  logic [COUNT_BITS-1:0] wdc;
  logic [COUNT_BITS-1:0] wdm;
  logic                  needs_mem;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [AW-1:0] tab_addr(input mdh_cmd_t c);
    tab_addr = AW'(AW'(c.dim) * AW'(MAX_BINS) + AW'(c.bin));
  endfunction

  assign empty = !out_v_r;
  assign q_pop = (st_r == B_IDLE) && !q_empty && !out_v_r;
  assign ra    = tab_addr(q_cmd);
  assign needs_mem = q_cmd.dim_ok &&
                     (q_cmd.op == OP_ACC || (q_cmd.op == OP_READ && q_cmd.in_range));

  // Write port: clearing sweep or accumulate update.
  always_comb begin
    we  = 1'b0;
    wa  = tab_addr(cmd_r);
    wdc = sat_inc(rdc_r);
    wdm = cmd_r.hl ? sat_inc(rdm_r) : rdm_r;
    if (st_r == B_CLR) begin
      we  = 1'b1;
      wa  = clr_addr_r;
      wdc = '0;
      wdm = '0;
    end else if (st_r == B_EX && cmd_r.op == OP_ACC) begin
      we = 1'b1;
    end
  end

  // Count memories with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      cnt_mem[wa] <= wdc;
      mrk_mem[wa] <= wdm;
    end
    rdc_r <= cnt_mem[ra];
    rdm_r <= mrk_mem[ra];
  end

  // Sequencer, maxima and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_CLR;
      clr_addr_r <= '0;
      clr_res_r  <= 1'b0;
      out_v_r    <= 1'b0;
      for (int i = 0; i < DIMS; i++) begin
        max_r[i] <= '0;
      end
    end else begin
      if (pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      case (st_r)
        B_CLR: begin
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            st_r <= B_IDLE;
            if (clr_res_r) begin
              out_v_r           <= 1'b1;
              out_bin_index     <= '0;
              out_bin_count     <= '0;
              out_marked_count  <= '0;
              out_dim_max_count <= '0;
            end
          end else begin
            clr_addr_r <= clr_addr_r + AW'(1);
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            if (q_cmd.op == OP_CLEAR) begin
              st_r       <= B_CLR;
              clr_addr_r <= '0;
              clr_res_r  <= 1'b1;
              for (int i = 0; i < DIMS; i++) begin
                max_r[i] <= '0;
              end
            end else if (needs_mem) begin
              st_r <= B_EX;
            end else begin
              out_v_r          <= 1'b1;
              out_bin_count    <= '0;
              out_marked_count <= '0;
              if (q_cmd.op == OP_READ && q_cmd.dim_ok) begin
                out_bin_index     <= q_cmd.bin[5:0];
                out_dim_max_count <= 32'(max_r[DW'(q_cmd.dim)]);
              end else begin
                out_bin_index     <= '0;
                out_dim_max_count <= '0;
              end
            end
          end
        end
        B_EX: begin
          st_r          <= B_IDLE;
          out_v_r       <= 1'b1;
          out_bin_index <= cmd_r.bin[5:0];
          if (cmd_r.op == OP_ACC) begin
            out_bin_count    <= 32'(wdc);
            out_marked_count <= 32'(wdm);
            if (wdc > max_r[DW'(cmd_r.dim)]) begin
              max_r[DW'(cmd_r.dim)] <= wdc;
              out_dim_max_count     <= 32'(wdc);
            end else begin
              out_dim_max_count <= 32'(max_r[DW'(cmd_r.dim)]);
            end
          end else begin
            out_bin_count     <= 32'(rdc_r);
            out_marked_count  <= 32'(rdm_r);
            out_dim_max_count <= 32'(max_r[DW'(cmd_r.dim)]);
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // No command leaves the queue while the tables are being swept.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CLR) |-> !q_pop) else $error("command taken during clear");

  // A memory command always ends with a result in the register.
  a_ex_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_EX) |=> out_v_r) else $error("memory command lost its result");

  // A memory command only starts with the result register free.
  a_ex_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_EX) |-> !out_v_r) else $error("result overwritten");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the multi-dimension histogram engine
// Programs bin numbers and per-dimension ranges, streams accumulate, read
// and clear items with random gaps and result-side stalls, and compares
// every result against a bit-accurate histogram model.
// ----------------------------------------------------------------------------
module tb_top;
  import mdh_pkg::*;

  localparam int NDIM   = 16;
  localparam int NBIN   = 64;
  localparam int LIMIT  = 20000;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Scoreboard that tracks the histogram tables and expected results.
  class hist_scoreboard;
    bit [6:0]  bins_reg;
    bit [3:0]  rdim_reg;
    bit [31:0] rlow_reg, rhigh_reg;
    bit [31:0] lo_bnd[NDIM], hi_bnd[NDIM];
    bit [31:0] cnt[NDIM*NBIN], mcnt[NDIM*NBIN], maxc[NDIM];
    bit [101:0] pending[$];
    int errors;

    function new();
      bins_reg = 7'd10;
      errors = 0;
      foreach (lo_bnd[i]) begin lo_bnd[i] = 0; hi_bnd[i] = 0; maxc[i] = 0; end
      foreach (cnt[i]) begin cnt[i] = 0; mcnt[i] = 0; end
    endfunction

    function void write_reg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        REG_BINS: bins_reg = val[6:0];
        REG_RDIM: rdim_reg = val[3:0];
        REG_RLOW: rlow_reg = val;
        default: begin
          rhigh_reg = val;
          lo_bnd[rdim_reg] = rlow_reg;
          hi_bnd[rdim_reg] = rhigh_reg;
        end
      endcase
    endfunction

    function bit [31:0] sat_inc(bit [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 1;
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(bit [1:0] op, bit [3:0] d, bit [31:0] v, bit hl,
                            bit [5:0] sel);
      longint lo, hi, sv, n, bin;
      int k;
      bit [5:0] bi;
      bit [31:0] bc, mc, mx;
      n = (bins_reg == 0) ? 1 : (bins_reg > NBIN ? NBIN : bins_reg);
      bi = 0; bc = 0; mc = 0; mx = 0;
      if (op == OP_ACC) begin
        lo = longint'($signed(lo_bnd[d]));
        hi = longint'($signed(hi_bnd[d]));
        sv = longint'($signed(v));
        if (hi <= lo || sv < lo) bin = 0;
        else if (sv >= hi) bin = n - 1;
        else bin = ((sv - lo) * n) / (hi - lo);
        k = d * NBIN + int'(bin);
        cnt[k] = sat_inc(cnt[k]);
        if (hl) mcnt[k] = sat_inc(mcnt[k]);
        if (cnt[k] > maxc[d]) maxc[d] = cnt[k];
        bi = bin[5:0]; bc = cnt[k]; mc = mcnt[k]; mx = maxc[d];
      end else if (op == OP_READ) begin
        bi = sel;
        mx = maxc[d];
        if (sel < n) begin
          bc = cnt[d*NBIN+sel]; mc = mcnt[d*NBIN+sel];
        end
      end else if (op == OP_CLEAR) begin
        foreach (cnt[i]) begin cnt[i] = 0; mcnt[i] = 0; end
        foreach (maxc[i]) maxc[i] = 0;
      end
      pending.push_back({bi, bc, mc, mx});
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(bit [5:0] bi, bit [31:0] bc, bit [31:0] mc,
                               bit [31:0] mx);
      bit [101:0] e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e[101:96] !== bi) begin
        $error("bin_index exp %0d got %0d", e[101:96], bi); errors++;
      end
      if (e[95:64] !== bc) begin
        $error("bin_count exp %0d got %0d", e[95:64], bc); errors++;
      end
      if (e[63:32] !== mc) begin
        $error("marked_count exp %0d got %0d", e[63:32], mc); errors++;
      end
      if (e[31:0] !== mx) begin
        $error("dim_max_count exp %0d got %0d", e[31:0], mx); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic push, full, empty, pop;
  logic [1:0] in_operation;
  logic [3:0] in_dimension;
  logic signed [31:0] in_value;
  logic in_highlighted;
  logic [5:0] in_bin_select;
  logic [5:0] out_bin_index;
  logic [31:0] out_bin_count, out_marked_count, out_dim_max_count;

  hist_scoreboard sb;
  int idle_cycles;
  bit stim_done;
  bit calm;

  multi_dim_histogram dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .in_operation(in_operation),
    .in_dimension(in_dimension), .in_value(in_value),
    .in_highlighted(in_highlighted), .in_bin_select(in_bin_select),
    .empty(empty), .pop(pop), .out_bin_index(out_bin_index),
    .out_bin_count(out_bin_count), .out_marked_count(out_marked_count),
    .out_dim_max_count(out_dim_max_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Writes one register through the configuration port.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_range(logic [3:0] d, logic [31:0] lo, logic [31:0] hi);
    write_reg(REG_RDIM, {28'd0, d});
    write_reg(REG_RLOW, lo);
    write_reg(REG_RHIGH, hi);
  endtask

  // Presents one item after a random gap and waits until it is taken.
  // With no gap the next item follows at once and push stays high.
  task automatic send_item(logic [1:0] op, logic [3:0] d, logic [31:0] v,
                           logic hl, logic [5:0] sel);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1; in_operation <= op; in_dimension <= d;
    in_value <= v; in_highlighted <= hl; in_bin_select <= sel;
    do @(posedge clk); while (full);
    sb.note_item(op, d, v, hl, sel);
  endtask

  // Waits until every expected result has come back, then lets the block settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // A value near a bin edge of dimension d, or anywhere at random.
  function automatic logic [31:0] pick_value(logic [3:0] d);
    longint lo, hi, span;
    lo = longint'($signed(sb.lo_bnd[d]));
    hi = longint'($signed(sb.hi_bnd[d]));
    span = hi - lo;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return sb.lo_bnd[d] + $urandom_range(0, 2) - 1;
      2: return sb.hi_bnd[d] + $urandom_range(0, 2) - 1;
      default: begin
        if (span <= 0) return $urandom;
        return 32'(lo + longint'($urandom) % span);
      end
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [1:0] op;
    logic [3:0] d;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 80) ? OP_ACC : (r < 97 ? OP_READ : (r < 99 ? OP_NONE : OP_CLEAR));
      d = 4'($urandom_range(0, 15));
      send_item(op, d, pick_value(d), 1'($urandom_range(0, 1)),
                6'($urandom_range(0, 63)));
    end
  endtask

  // Result side: random stalls, then accepts the result at hand.
  // With no stall pop stays high for the next result.
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_bin_index, out_bin_count, out_marked_count,
                      out_dim_max_count);
    end
  end

  // Watchdog over cycles without any accepted item or result.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    sb = new();
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; push = 1'b0; in_operation = OP_ACC;
    in_dimension = '0; in_value = '0; in_highlighted = 1'b0;
    in_bin_select = '0; idle_cycles = 0; stim_done = 0; calm = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: empty ranges go to bin 0.
    send_item(OP_ACC, 4'd0, 32'h7FFF_FFFF, 1'b1, 6'd0);
    send_item(OP_READ, 4'd0, 32'd0, 1'b0, 6'd0);
    send_item(OP_READ, 4'd0, 32'd0, 1'b0, 6'd63);
    send_item(OP_NONE, 4'd3, 32'hFFFF_FFFF, 1'b1, 6'd63);
    drain();
    set_range(4'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    set_range(4'd2, 32'd100, 32'd50);
    set_range(4'd15, 32'hFFFF_FF00, 32'd256);
    send_item(OP_ACC, 4'd1, 32'h8000_0000, 1'b1, 6'd0);
    send_item(OP_ACC, 4'd1, 32'h7FFF_FFFE, 1'b0, 6'd0);
    send_item(OP_ACC, 4'd1, 32'h7FFF_FFFF, 1'b1, 6'd0);
    send_item(OP_ACC, 4'd2, 32'd75, 1'b1, 6'd0);
    send_item(OP_ACC, 4'd15, 32'hFFFF_FEFF, 1'b0, 6'd0);
    send_item(OP_ACC, 4'd15, 32'd255, 1'b1, 6'd0);
    send_item(OP_ACC, 4'd15, 32'd0, 1'b1, 6'd0);
    send_item(OP_READ, 4'd15, 32'd0, 1'b0, 6'd9);
    send_item(OP_READ, 4'd15, 32'd0, 1'b0, 6'd10);
    send_item(OP_CLEAR, 4'd0, 32'd0, 1'b0, 6'd0);
    send_item(OP_READ, 4'd1, 32'd0, 1'b0, 6'd9);
    drain();

    // Bin number extremes, including 0 and beyond the table size.
    write_reg(REG_BINS, 32'd0);
    send_item(OP_ACC, 4'd15, 32'd200, 1'b1, 6'd0);
    drain();
    write_reg(REG_BINS, 32'd127);
    send_item(OP_ACC, 4'd15, 32'd255, 1'b1, 6'd0);
    send_item(OP_READ, 4'd15, 32'd0, 1'b0, 6'd63);
    drain();

    // Random phases over several settings and ranges.
    for (int ph = 0; ph < 14; ph++) begin
      calm = (ph % 5 == 4);
      write_reg(REG_BINS, (ph == 0) ? 32'd64 : (ph == 1 ? 32'd1 : $urandom_range(0, 127)));
      for (int j = 0; j < 3; j++)
        set_range(4'($urandom_range(0, 15)), $urandom, $urandom);
      set_range(4'($urandom_range(0, 15)), 32'(-$urandom_range(0, 1000)),
                32'($urandom_range(0, 1000)));
      random_phase(100);
      drain();
    end
    stim_done = 1;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
